// ===== hw/rtl/mpns_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the mouse packet nibble serializer
package mpns_pkg;

  typedef enum logic [1:0] {
    OP_ADD_MOTION  = 2'd0,
    OP_SET_BUTTONS = 2'd1,
    OP_POLL        = 2'd2,
    OP_RESTART     = 2'd3
  } op_e;

  // which packet byte a nibble position reads
  typedef enum logic [1:0] {
    BYTE_ID      = 2'd0,
    BYTE_CONTROL = 2'd1,
    BYTE_MAG_X   = 2'd2,
    BYTE_MAG_Y   = 2'd3
  } byte_sel_e;

  localparam logic [7:0] DEVICE_ID_RESET = 8'd227;
  localparam logic [2:0] LAST_NIBBLE     = 3'd7;

  typedef struct packed {
    op_e                operation;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
    logic               button_left;
    logic               button_right;
    logic               button_middle;
    logic               button_start;
    logic               select0;
    logic               select1;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
    logic       packet_end;
  } result_t;

endpackage

// ===== hw/rtl/mouse_packet_nibble_serializer.sv =====
`timescale 1ns / 1ps
// top level: input register, state core and result register with handshakes
//
//  port group   direction  flow control         carries
//  in_*         input      valid / stall        operation, steps, buttons, selects
//  out_*        output     valid / stall        nibble, packet_end
//  cfg_*        input      valid / ready        device id byte
//
// one item per cycle unless in_stall_o; poll results go via input then result register
// the core updates its state in the cycle an item leaves the input register
// items with no result leave the input register even while the output is stalled
// reset clears motion, buttons, poll history and sets the device id to 227
module mouse_packet_nibble_serializer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic signed [15:0] step_x_i,
  input  logic signed [15:0] step_y_i,
  input  logic        button_left_i,
  input  logic        button_right_i,
  input  logic        button_middle_i,
  input  logic        button_start_i,
  input  logic        select0_i,
  input  logic        select1_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  nibble_o,
  output logic        packet_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_device_id_i
);

  mpns_pkg::item_t   item_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic [3:0]        nibble_q;
  logic              pkt_end_q;
  logic [7:0]        device_id_q;
  mpns_pkg::result_t res;
  logic              out_free, advance, in_xfer;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!res.valid || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  mpns_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (item_q),
    .device_id_i (device_id_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      device_id_q <= mpns_pkg::DEVICE_ID_RESET;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance && res.valid) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        device_id_q <= cfg_device_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.operation     <= mpns_pkg::op_e'(operation_i);
      item_q.step_x        <= step_x_i;
      item_q.step_y        <= step_y_i;
      item_q.button_left   <= button_left_i;
      item_q.button_right  <= button_right_i;
      item_q.button_middle <= button_middle_i;
      item_q.button_start  <= button_start_i;
      item_q.select0       <= select0_i;
      item_q.select1       <= select1_i;
    end
    if (advance && res.valid) begin
      nibble_q  <= res.nibble;
      pkt_end_q <= res.packet_end;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign nibble_o     = nibble_q;
  assign packet_end_o = pkt_end_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && res.valid && out_vld_q))
    else $error("input stalled without a blocked poll");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid) |=> out_vld_q)
    else $error("poll result lost");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !(advance && res.valid))
    else $error("stalled result overwritten");

endmodule

// ===== hw/rtl/mpns_core.sv =====
`timescale 1ns / 1ps
// motion, button and poll state with the nibble selection logic
module mpns_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  mpns_pkg::item_t    item_i,
  input  logic [7:0]         device_id_i,
  output mpns_pkg::result_t  result_o
);

  logic signed [8:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic              ovf_x_q, ovf_x_d, ovf_y_q, ovf_y_d;
  logic [3:0]        buttons_q, buttons_d;
  logic [1:0]        last_sel_q, last_sel_d;
  logic              sel_vld_q, sel_vld_d;
  logic [7:0]        pos_q, pos_d;

  logic signed [16:0] sum_x, sum_y;
  logic [1:0]         sel;
  logic               advance;
  logic [2:0]         rd_pos;
  logic [7:0]         ctrl_byte, mag_x, mag_y, byte_val;
  logic               is_poll, pkt_end;

  assign sum_x = {{8{acc_x_q[8]}}, acc_x_q} + {item_i.step_x[15], item_i.step_x};
  assign sum_y = {{8{acc_y_q[8]}}, acc_y_q} + {item_i.step_y[15], item_i.step_y};

  assign sel     = {item_i.select1, item_i.select0};
  assign is_poll = (item_i.operation == mpns_pkg::OP_POLL);
  // no poll seen since reset or restart counts as a change
  assign advance = !sel_vld_q || (sel != last_sel_q);
  assign pkt_end = advance && (pos_q[2:0] == mpns_pkg::LAST_NIBBLE);

  // a repeat shows the nibble last sent, or nibble 0 when the count sits at zero
  always_comb begin
    if (advance) begin
      rd_pos = pos_q[2:0];
    end else if (pos_q == 8'd0) begin
      rd_pos = 3'd0;
    end else begin
      rd_pos = pos_q[2:0] - 3'd1;
    end
  end

  assign ctrl_byte = {ovf_y_q, ovf_x_q, acc_y_q[8], acc_x_q[8], buttons_q};
  assign mag_x = acc_x_q[8] ? 8'(-acc_x_q) : acc_x_q[7:0];
  assign mag_y = acc_y_q[8] ? 8'(-acc_y_q) : acc_y_q[7:0];

  always_comb begin
    unique case (mpns_pkg::byte_sel_e'(rd_pos[2:1]))
      mpns_pkg::BYTE_ID:      byte_val = device_id_i;
      mpns_pkg::BYTE_CONTROL: byte_val = ctrl_byte;
      mpns_pkg::BYTE_MAG_X:   byte_val = mag_x;
      mpns_pkg::BYTE_MAG_Y:   byte_val = mag_y;
      default:                byte_val = device_id_i;
    endcase
  end

  assign result_o.valid      = is_poll;
  assign result_o.nibble     = rd_pos[0] ? byte_val[3:0] : byte_val[7:4];
  assign result_o.packet_end = pkt_end;

  always_comb begin
    acc_x_d    = acc_x_q;
    acc_y_d    = acc_y_q;
    ovf_x_d    = ovf_x_q;
    ovf_y_d    = ovf_y_q;
    buttons_d  = buttons_q;
    last_sel_d = last_sel_q;
    sel_vld_d  = sel_vld_q;
    pos_d      = pos_q;
    unique case (item_i.operation)
      mpns_pkg::OP_ADD_MOTION: begin
        if (sum_x > 17'sd255) begin
          acc_x_d = 9'sd255;
          ovf_x_d = 1'b1;
        end else if (sum_x < -17'sd255) begin
          acc_x_d = -9'sd255;
          ovf_x_d = 1'b1;
        end else begin
          acc_x_d = sum_x[8:0];
        end
        if (sum_y > 17'sd255) begin
          acc_y_d = 9'sd255;
          ovf_y_d = 1'b1;
        end else if (sum_y < -17'sd255) begin
          acc_y_d = -9'sd255;
          ovf_y_d = 1'b1;
        end else begin
          acc_y_d = sum_y[8:0];
        end
      end
      mpns_pkg::OP_SET_BUTTONS: begin
        buttons_d = {item_i.button_start, item_i.button_middle,
                     item_i.button_right, item_i.button_left};
      end
      mpns_pkg::OP_POLL: begin
        if (advance) begin
          pos_d      = pos_q + 8'd1;
          last_sel_d = sel;
          sel_vld_d  = 1'b1;
          if (pkt_end) begin
            acc_x_d = '0;
            acc_y_d = '0;
            ovf_x_d = 1'b0;
            ovf_y_d = 1'b0;
          end
        end
      end
      mpns_pkg::OP_RESTART: begin
        pos_d     = '0;
        sel_vld_d = 1'b0;
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q    <= '0;
      acc_y_q    <= '0;
      ovf_x_q    <= 1'b0;
      ovf_y_q    <= 1'b0;
      buttons_q  <= '0;
      last_sel_q <= '0;
      sel_vld_q  <= 1'b0;
      pos_q      <= '0;
    end else if (fire_i) begin
      acc_x_q    <= acc_x_d;
      acc_y_q    <= acc_y_d;
      ovf_x_q    <= ovf_x_d;
      ovf_y_q    <= ovf_y_d;
      buttons_q  <= buttons_d;
      last_sel_q <= last_sel_d;
      sel_vld_q  <= sel_vld_d;
      pos_q      <= pos_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_poll && pkt_end) |=>
      (acc_x_q == 9'sd0 && acc_y_q == 9'sd0 && !ovf_x_q && !ovf_y_q))
    else $error("motion not cleared after packet end");

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_x_q != -9'sd256) && (acc_y_q != -9'sd256))
    else $error("accumulator outside saturation range");

  a_poll_marks_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_poll) |=> sel_vld_q)
    else $error("select history not recorded after poll");

  a_repeat_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_poll && !advance) |=> $stable(pos_q))
    else $error("repeat poll moved packet position");

endmodule
